[hw/rtl/skce_pkg.sv]
// ----------------------------------------------------------------------------
// skce_pkg
// Shared types and constants for the scan code key event queue: key codes,
// lock bit positions, operation kinds and the configuration register map.
// ----------------------------------------------------------------------------
package skce_pkg;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;

    localparam logic [7:0] KEY_LCTRL  = 8'h1D;
    localparam logic [7:0] KEY_LSHIFT = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT = 8'h36;
    localparam logic [7:0] KEY_LALT   = 8'h38;
    localparam logic [7:0] KEY_CAPS   = 8'h3A;
    localparam logic [7:0] KEY_NUM    = 8'h45;
    localparam logic [7:0] KEY_SCROLL = 8'h46;
    localparam logic [7:0] KEY_RCTRL  = 8'h9D;
    localparam logic [7:0] KEY_RALT   = 8'hB8;
    localparam logic [7:0] KEY_CLEAR  = 8'hC6;

    localparam int LOCK_NUM_BIT    = 0;
    localparam int LOCK_CAPS_BIT   = 1;
    localparam int LOCK_SCROLL_BIT = 2;

    localparam logic [1:0] KIND_POP    = 2'd0;
    localparam logic [1:0] KIND_PREFIX = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;

    localparam int          PADDR_W             = 3;
    localparam logic [2:0]  ADDR_ENGLISH_LAYOUT = 3'h0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic       press;
    } op_t;

    typedef struct packed {
        logic valid;
        logic full;
    } opq_status_t;

endpackage

[hw/rtl/skce_in_if.sv]
// ----------------------------------------------------------------------------
// skce_in_if
// Input channel: scan byte or pop command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface skce_in_if;

    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] scan_byte;

    modport source (output valid, command, scan_byte, input ready);
    modport sink   (input valid, command, scan_byte, output ready);

endinterface

[hw/rtl/skce_out_if.sv]
// ----------------------------------------------------------------------------
// skce_out_if
// Result channel: popped event and current keyboard status.
// ----------------------------------------------------------------------------
interface skce_out_if;

    logic       valid;
    logic       ready;
    logic       got_key;
    logic [7:0] key_code;
    logic [8:0] modifiers;
    logic [7:0] keys_held;
    logic [2:0] lock_state;
    logic       dropped;

    modport source (output valid, got_key, key_code, modifiers, keys_held, lock_state,
                    dropped, input ready);
    modport sink   (input valid, got_key, key_code, modifiers, keys_held, lock_state,
                    dropped, output ready);

endinterface

[hw/rtl/scan_code_key_event_queue.sv]
// ----------------------------------------------------------------------------
// scan_code_key_event_queue
// Path: an input transfer is registered in the operation queue, then the
// table/memory update is registered into the result register.
// Throughput: one item per cycle while evt_out.ready does not hold the result,
// set by the key table and event memory update in the back end.
// Reset: key table, counts, locks and indexes clear at once; english_layout
// resets to 1; event memory content is not cleared and is never read unwritten.
// ----------------------------------------------------------------------------
module scan_code_key_event_queue import skce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    skce_in_if.sink            key_in,
    skce_out_if.source         evt_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        english_layout_reg;
    logic        english_layout_next;
    logic        push;
    op_t         push_op;
    logic        pop;
    op_t         head_op;
    opq_status_t q_status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ENGLISH_LAYOUT) ? {31'b0, english_layout_reg} : 32'b0;

    always_comb
    begin
        english_layout_next = english_layout_reg;
        if (psel && penable && pwrite && pready && (paddr == ADDR_ENGLISH_LAYOUT))
        begin
            english_layout_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            english_layout_reg <= 1'b1;
        end
        else
        begin
            english_layout_reg <= english_layout_next;
        end
    end

    skce_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_in),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    skce_opq u_opq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .status  (q_status),
        .head_op (head_op)
    );

    skce_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .english_layout (english_layout_reg),
        .q_status       (q_status),
        .op             (head_op),
        .pop            (pop),
        .evt_out        (evt_out)
    );

endmodule

[hw/rtl/skce_front.sv]
// ----------------------------------------------------------------------------
// skce_front
// Accept input transfers, track the extended prefix and classify each item
// as pop, prefix or key press/release.
// ----------------------------------------------------------------------------
module skce_front import skce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    skce_in_if.sink     key_in,
    input  opq_status_t q_status,
    output logic        push,
    output op_t         push_op
);

    logic ext_reg;
    logic ext_next;

    assign key_in.ready = !q_status.full;
    assign push         = key_in.valid && key_in.ready;

    always_comb
    begin
        push_op.code  = {ext_reg, key_in.scan_byte[6:0]};
        push_op.press = !key_in.scan_byte[7];
        if (key_in.command)
        begin
            push_op.kind = KIND_POP;
        end
        else if (key_in.scan_byte == PREFIX_BYTE)
        begin
            push_op.kind = KIND_PREFIX;
        end
        else
        begin
            push_op.kind = KIND_KEY;
        end
    end

    always_comb
    begin
        ext_next = ext_reg;
        if (push && !key_in.command)
        begin
            ext_next = (key_in.scan_byte == PREFIX_BYTE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b0;
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

endmodule

[hw/rtl/skce_opq.sv]
// ----------------------------------------------------------------------------
// skce_opq
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module skce_opq import skce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  op_t         push_op,
    input  logic        pop,
    output opq_status_t status,
    output op_t         head_op
);

    op_t        slot_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign head_op      = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/skce_back.sv]
// ----------------------------------------------------------------------------
// skce_back
// Execute operations: key table, held count, lock flags, event memory and
// the registered result stage.
// ----------------------------------------------------------------------------
module skce_back import skce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        english_layout,
    input  opq_status_t q_status,
    input  op_t         op,
    output logic        pop,
    skce_out_if.source  evt_out
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [16:0]   mem [QUEUE_DEPTH];

    logic [255:0]  key_down_reg;
    logic [255:0]  key_down_next;
    logic [7:0]    held_reg;
    logic [7:0]    held_next;
    logic [2:0]    lock_reg;
    logic [2:0]    lock_next;
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] rd_reg;
    logic [AW-1:0] rd_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic          got_reg;
    logic [7:0]    code_reg;
    logic [8:0]    mods_reg;
    logic [7:0]    held_out_reg;
    logic [2:0]    lock_out_reg;
    logic          drop_reg;

    logic          adv;
    logic          is_key;
    logic          is_scan;
    logic          is_pop;
    logic          was_down;
    logic [255:0]  down_upd;
    logic [7:0]    held_upd;
    logic          ctrl;
    logic [8:0]    mods;
    logic [AW-1:0] wr_inc;
    logic [AW-1:0] rd_inc;
    logic          fifo_full;
    logic          fifo_nonempty;
    logic          enq;
    logic          drop;
    logic          clear;
    logic          deq;

    assign adv     = q_status.valid && (!out_valid_reg || evt_out.ready);
    assign pop     = adv;
    assign is_key  = adv && (op.kind == KIND_KEY);
    assign is_scan = adv && (op.kind != KIND_POP);
    assign is_pop  = adv && (op.kind == KIND_POP);

    assign was_down = key_down_reg[op.code];

    always_comb
    begin
        down_upd = key_down_reg;
        held_upd = held_reg;
        if (is_key)
        begin
            down_upd[op.code] = op.press;
            if (op.press && !was_down)
            begin
                held_upd = held_reg + 8'd1;
            end
            else if (!op.press && was_down)
            begin
                held_upd = held_reg - 8'd1;
            end
        end
    end

    assign ctrl = down_upd[KEY_LCTRL] || down_upd[KEY_RCTRL];

    always_comb
    begin
        lock_next = lock_reg;
        if (is_key && op.press)
        begin
            unique case (op.code) inside
                KEY_CAPS:
                begin
                    if (!ctrl && (!lock_reg[LOCK_CAPS_BIT] || english_layout))
                    begin
                        lock_next[LOCK_CAPS_BIT] = ~lock_reg[LOCK_CAPS_BIT];
                    end
                end
                KEY_NUM:
                begin
                    if (!ctrl)
                    begin
                        lock_next[LOCK_NUM_BIT] = ~lock_reg[LOCK_NUM_BIT];
                    end
                end
                KEY_SCROLL:
                begin
                    if (!ctrl)
                    begin
                        lock_next[LOCK_SCROLL_BIT] = ~lock_reg[LOCK_SCROLL_BIT];
                    end
                end
                KEY_LSHIFT, KEY_RSHIFT:
                begin
                    if (lock_reg[LOCK_CAPS_BIT] && !english_layout)
                    begin
                        lock_next[LOCK_CAPS_BIT] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mods = {lock_next[LOCK_SCROLL_BIT], lock_next[LOCK_CAPS_BIT],
                   lock_next[LOCK_NUM_BIT],
                   down_upd[KEY_RCTRL], down_upd[KEY_LCTRL],
                   down_upd[KEY_RALT], down_upd[KEY_LALT],
                   down_upd[KEY_RSHIFT], down_upd[KEY_LSHIFT]};

    assign wr_inc        = (wr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + AW'(1);
    assign rd_inc        = (rd_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + AW'(1);
    assign fifo_full     = (wr_inc == rd_reg);
    assign fifo_nonempty = (rd_reg != wr_reg);
    assign enq           = is_key && op.press && !fifo_full;
    assign drop          = is_key && op.press && fifo_full;
    assign deq           = is_pop && fifo_nonempty;
    assign clear         = is_scan && down_upd[KEY_CLEAR];

    always_comb
    begin
        key_down_next = clear ? '0 : down_upd;
        held_next     = clear ? 8'd0 : held_upd;
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        if (clear)
        begin
            wr_next = '0;
            rd_next = '0;
        end
        else
        begin
            if (enq)
            begin
                wr_next = wr_inc;
            end
            if (deq)
            begin
                rd_next = rd_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Event memory: write on enqueue, registered read into the result stage.
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem[wr_reg] <= {mods, op.code};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (deq)
            begin
                {mods_reg, code_reg} <= mem[rd_reg];
            end
            else
            begin
                {mods_reg, code_reg} <= '0;
            end
            got_reg      <= deq;
            held_out_reg <= held_next;
            lock_out_reg <= lock_next;
            drop_reg     <= drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg  <= '0;
            held_reg      <= 8'd0;
            lock_reg      <= 3'd0;
            wr_reg        <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_down_reg  <= key_down_next;
            held_reg      <= held_next;
            lock_reg      <= lock_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign evt_out.valid      = out_valid_reg;
    assign evt_out.got_key    = got_reg;
    assign evt_out.key_code   = code_reg;
    assign evt_out.modifiers  = mods_reg;
    assign evt_out.keys_held  = held_out_reg;
    assign evt_out.lock_state = lock_out_reg;
    assign evt_out.dropped    = drop_reg;

endmodule
